/* rtl/lsr_pkg.sv */
// Types and constants shared by the line span rasterizer.
// Request/result payload structs, rasterizer state struct, span kind codes.
// No dependencies.
package lsr_pkg;

   localparam int COORD_BITS  = 10;
   localparam int POS_BITS    = COORD_BITS + 1;
   localparam int ERR_BITS    = COORD_BITS + 2;
   localparam int LEN_BITS    = COORD_BITS + 1;
   localparam int COLOUR_BITS = 16;

   localparam logic KIND_START = 1'b0;
   localparam logic KIND_STEP  = 1'b1;

   localparam logic [1:0] SPAN_HORIZ = 2'd0;
   localparam logic [1:0] SPAN_VERT  = 2'd1;
   localparam logic [1:0] SPAN_PIXEL = 2'd2;

   typedef struct packed {
      logic                   kind;
      logic [COORD_BITS-1:0]  first_x;
      logic [COORD_BITS-1:0]  first_y;
      logic [COORD_BITS-1:0]  end_x;
      logic [COORD_BITS-1:0]  end_y;
      logic [COLOUR_BITS-1:0] colour;
   } lsr_req_type;

   typedef struct packed {
      logic                   span_valid;
      logic [COORD_BITS-1:0]  span_x;
      logic [COORD_BITS-1:0]  span_y;
      logic [LEN_BITS-1:0]    run_length;
      logic [1:0]             span_kind;
      logic [COLOUR_BITS-1:0] span_colour;
      logic                   done_res;
   } lsr_rsp_type;

   typedef struct packed {
      logic                       busy;
      logic [POS_BITS-1:0]        major_pos;
      logic [POS_BITS-1:0]        minor_pos;
      logic [POS_BITS-1:0]        major_end;
      logic [POS_BITS-1:0]        major_delta;
      logic [POS_BITS-1:0]        minor_delta;
      logic signed [ERR_BITS-1:0] error_acc;
      logic                       minor_down;
      logic                       steep_flag;
      logic [POS_BITS-1:0]        run_begin;
      logic [COLOUR_BITS-1:0]     line_colour;
   } lsr_state_type;

endpackage

/* rtl/line_span_rasterizer_core.sv */
// Line span rasterizer top level: handshake, state registers and per-step span logic.
// Depends on lsr_pkg and lsr_setup.
//
// Bresenham rasterizer that emits horizontal/vertical runs instead of single pixels.
// A start transfer (kind 0) loads a line and answers at once; each step transfer
// (kind 1) advances one major-axis position. Every request transfer yields exactly
// one response transfer; the response is registered and is valid in the cycle after
// its request is accepted. One request is taken per clock: the step is a single
// subtract, compare and add on the state registers, and req_ready only drops when the
// response register is full and rsp_ready is low.
module line_span_rasterizer_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  lsr_pkg::lsr_req_type  req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output lsr_pkg::lsr_rsp_type  rsp_data
);
   import lsr_pkg::*;

   lsr_state_type state_ff, state_in;
   lsr_rsp_type   rsp_data_ff, rsp_data_in;
   logic          rsp_valid_ff, rsp_valid_in;

   lsr_rsp_type   setup_rsp;
   lsr_state_type setup_state;

   logic                       req_xfer;
   logic signed [ERR_BITS-1:0] err;
   logic                       err_neg;
   logic [POS_BITS-1:0]        pos;
   logic [POS_BITS-1:0]        run_len;
   logic                       last_pos;
   lsr_rsp_type                step_rsp;
   lsr_rsp_type                run_rsp;
   lsr_state_type              step_state;

   lsr_setup u_setup (
      .req_data    (req_data),
      .setup_rsp   (setup_rsp),
      .setup_state (setup_state)
   );

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_xfer  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      pos      = state_ff.major_pos;
      err      = state_ff.error_acc - $signed({1'b0, state_ff.minor_delta});
      err_neg  = err[ERR_BITS-1];
      run_len  = pos - state_ff.run_begin;
      last_pos = pos >= state_ff.major_end;

      run_rsp             = '0;
      run_rsp.span_valid  = 1'b1;
      run_rsp.run_length  = run_len + LEN_BITS'(1);
      run_rsp.span_colour = state_ff.line_colour;
      if (state_ff.steep_flag) begin
         run_rsp.span_x    = state_ff.minor_pos[COORD_BITS-1:0];
         run_rsp.span_y    = state_ff.run_begin[COORD_BITS-1:0];
         run_rsp.span_kind = SPAN_VERT;
      end else begin
         run_rsp.span_x    = state_ff.run_begin[COORD_BITS-1:0];
         run_rsp.span_y    = state_ff.minor_pos[COORD_BITS-1:0];
         run_rsp.span_kind = SPAN_HORIZ;
      end

      step_state = state_ff;
      step_rsp   = '0;
      if (!state_ff.busy) begin
         step_rsp.done_res = 1'b1;
      end else begin
         step_state.error_acc = err;
         if (err_neg) begin
            if (run_len != '0) begin
               step_rsp = run_rsp;
            end else begin
               step_rsp.span_valid  = 1'b1;
               step_rsp.run_length  = LEN_BITS'(1);
               step_rsp.span_kind   = SPAN_PIXEL;
               step_rsp.span_colour = state_ff.line_colour;
               step_rsp.span_x = state_ff.steep_flag ? state_ff.minor_pos[COORD_BITS-1:0]
                                                     : pos[COORD_BITS-1:0];
               step_rsp.span_y = state_ff.steep_flag ? pos[COORD_BITS-1:0]
                                                     : state_ff.minor_pos[COORD_BITS-1:0];
            end
            step_state.run_begin = pos + POS_BITS'(1);
            step_state.minor_pos = state_ff.minor_down ? state_ff.minor_pos - POS_BITS'(1)
                                                       : state_ff.minor_pos + POS_BITS'(1);
            step_state.error_acc = err + $signed({1'b0, state_ff.major_delta});
         end
         if (last_pos) begin
            step_state.busy = 1'b0;
            if (!err_neg && (run_len != '0)) begin
               step_rsp = run_rsp;
            end
            step_rsp.done_res = 1'b1;
         end else begin
            step_state.major_pos = pos + POS_BITS'(1);
         end
      end

      if (req_data.kind == KIND_START) begin
         state_in    = setup_state;
         rsp_data_in = setup_rsp;
      end else begin
         state_in    = step_state;
         rsp_data_in = step_rsp;
      end

      rsp_valid_in = rsp_valid_ff;
      if (req_xfer) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_xfer) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

/* rtl/lsr_setup.sv */
// Start decode for the line span rasterizer: degenerate lines and general line setup.
// Produces the start result and the loaded rasterizer state. Depends on lsr_pkg.
module lsr_setup (
   input  lsr_pkg::lsr_req_type   req_data,
   output lsr_pkg::lsr_rsp_type   setup_rsp,
   output lsr_pkg::lsr_state_type setup_state
);
   import lsr_pkg::*;

   logic [COORD_BITS-1:0] x1, y1, x2, y2;
   logic [COORD_BITS-1:0] adx, ady;
   logic [COORD_BITS-1:0] ax, ay, bx, by;
   logic [COORD_BITS-1:0] sax, say, sbx, sby;
   logic                  steep;
   logic [COORD_BITS-1:0] major_delta;
   logic [COORD_BITS-1:0] minor_delta;

   always_comb begin
      x1 = req_data.first_x;
      y1 = req_data.first_y;
      x2 = req_data.end_x;
      y2 = req_data.end_y;
      adx = (x2 > x1) ? x2 - x1 : x1 - x2;
      ady = (y2 > y1) ? y2 - y1 : y1 - y2;
      steep = ady > adx;

      sax = steep ? y1 : x1;
      say = steep ? x1 : y1;
      sbx = steep ? y2 : x2;
      sby = steep ? x2 : y2;
      if (sax > sbx) begin
         ax = sbx; ay = sby; bx = sax; by = say;
      end else begin
         ax = sax; ay = say; bx = sbx; by = sby;
      end
      major_delta = bx - ax;
      minor_delta = (ay > by) ? ay - by : by - ay;

      setup_state.busy        = 1'b1;
      setup_state.major_pos   = {1'b0, ax};
      setup_state.minor_pos   = {1'b0, ay};
      setup_state.major_end   = {1'b0, bx};
      setup_state.major_delta = {1'b0, major_delta};
      setup_state.minor_delta = {1'b0, minor_delta};
      setup_state.error_acc   = {3'b000, major_delta[COORD_BITS-1:1]};
      setup_state.minor_down  = !(ay < by);
      setup_state.steep_flag  = steep;
      setup_state.run_begin   = {1'b0, ax};
      setup_state.line_colour = req_data.colour;

      setup_rsp = '0;
      if (y1 == y2) begin
         setup_state.busy      = 1'b0;
         setup_rsp.span_valid  = 1'b1;
         setup_rsp.span_x      = (x2 < x1) ? x2 : x1;
         setup_rsp.span_y      = y1;
         setup_rsp.run_length  = {1'b0, adx} + LEN_BITS'(1);
         setup_rsp.span_kind   = (x1 == x2) ? SPAN_PIXEL : SPAN_HORIZ;
         setup_rsp.span_colour = req_data.colour;
         setup_rsp.done_res    = 1'b1;
      end else if (x1 == x2) begin
         setup_state.busy      = 1'b0;
         setup_rsp.span_valid  = 1'b1;
         setup_rsp.span_x      = x1;
         setup_rsp.span_y      = (y2 > y1) ? y1 : y2;
         setup_rsp.run_length  = {1'b0, ady} + LEN_BITS'(1);
         setup_rsp.span_kind   = SPAN_VERT;
         setup_rsp.span_colour = req_data.colour;
         setup_rsp.done_res    = 1'b1;
      end
   end

endmodule
